[src/assert_macros.svh]
// Assertion helpers used by the RTL. Empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[src/lfr_pkg.sv]
`timescale 1ns / 1ps

package lfr_pkg;

    // Frame characters
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_N = 8'h4E;

    // Link info payload codes
    localparam logic [7:0] INFO_LINK_UP   = 8'h01;
    localparam logic [7:0] INFO_LINK_DOWN = 8'h00;
    localparam logic [7:0] INFO_BLINK     = 8'h52;
    localparam logic [7:0] INFO_POWER_ON  = 8'h54;
    localparam logic [7:0] INFO_POWER_OFF = 8'h53;

    // Parser states
    localparam logic [2:0] PS_HUNT    = 3'd0;
    localparam logic [2:0] PS_GOT_M   = 3'd1;
    localparam logic [2:0] PS_GOT_A   = 3'd2;
    localparam logic [2:0] PS_PAYLOAD = 3'd3;
    localparam logic [2:0] PS_PANEL2  = 3'd4;

    // Frame types
    localparam logic [3:0] FT_NONE  = 4'd0;
    localparam logic [3:0] FT_PANEL = 4'd1;
    localparam logic [3:0] FT_INFO  = 4'd2;
    localparam logic [3:0] FT_RTEMP = 4'd3;
    localparam logic [3:0] FT_HOURS = 4'd4;
    localparam logic [3:0] FT_CMD   = 4'd5;
    localparam logic [3:0] FT_WIND  = 4'd6;
    localparam logic [3:0] FT_TIMER = 4'd7;
    localparam logic [3:0] FT_STEMP = 4'd8;
    localparam logic [3:0] FT_MIN   = 4'd9;
    localparam logic [3:0] FT_SEC   = 4'd10;

    // Update kinds
    localparam logic [4:0] KIND_NONE      = 5'd0;
    localparam logic [4:0] KIND_HUMIDITY  = 5'd1;
    localparam logic [4:0] KIND_PANEL_TMP = 5'd2;
    localparam logic [4:0] KIND_LINK_UP   = 5'd3;
    localparam logic [4:0] KIND_LINK_DOWN = 5'd4;
    localparam logic [4:0] KIND_BLINK     = 5'd5;
    localparam logic [4:0] KIND_POWER_ON  = 5'd6;
    localparam logic [4:0] KIND_POWER_OFF = 5'd7;
    localparam logic [4:0] KIND_INFO_UNK  = 5'd8;
    localparam logic [4:0] KIND_REAL_TMP  = 5'd9;
    localparam logic [4:0] KIND_COMMAND   = 5'd10;
    localparam logic [4:0] KIND_WIND      = 5'd11;
    localparam logic [4:0] KIND_TIMER_HRS = 5'd12;
    localparam logic [4:0] KIND_SET_TMP   = 5'd13;
    localparam logic [4:0] KIND_HOURS     = 5'd14;
    localparam logic [4:0] KIND_MINUTES   = 5'd15;
    localparam logic [4:0] KIND_SECONDS   = 5'd16;

    typedef struct packed {
        logic [2:0] parse_state;
        logic [3:0] frame_type;
        logic       decode_flag;
    } lfr_state_t;

    typedef struct packed {
        logic [4:0] update_kind;
        logic [7:0] value;
        logic       decode_ready;
    } lfr_result_t;

endpackage

[src/lfr_parser.sv]
`timescale 1ns / 1ps

module lfr_parser
    import lfr_pkg::*;
(
    input  logic [7:0]  rx_byte,
    input  lfr_state_t  state_cur,
    output lfr_state_t  state_next,
    output lfr_result_t res_next
);

    function automatic logic [3:0] letter_type(input logic [7:0] b);
        logic [3:0] t;
        unique case (b)
            CH_D:    t = FT_PANEL;
            CH_W:    t = FT_INFO;
            CH_P:    t = FT_RTEMP;
            CH_C:    t = FT_CMD;
            CH_B:    t = FT_HOURS;
            CH_S:    t = FT_WIND;
            CH_T:    t = FT_TIMER;
            CH_E:    t = FT_STEMP;
            CH_M:    t = FT_MIN;
            CH_N:    t = FT_SEC;
            default: t = FT_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] info_kind(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            INFO_LINK_UP:   k = KIND_LINK_UP;
            INFO_LINK_DOWN: k = KIND_LINK_DOWN;
            INFO_BLINK:     k = KIND_BLINK;
            INFO_POWER_ON:  k = KIND_POWER_ON;
            INFO_POWER_OFF: k = KIND_POWER_OFF;
            default:        k = KIND_INFO_UNK;
        endcase
        return k;
    endfunction

    logic [3:0] type_hit;

    assign type_hit = letter_type(rx_byte);

    always_comb begin
        state_next           = state_cur;
        res_next.update_kind = KIND_NONE;
        res_next.value       = 8'd0;
        unique case (state_cur.parse_state)
            PS_HUNT: begin
                if (rx_byte == CH_M) begin
                    state_next.parse_state = PS_GOT_M;
                end
            end
            PS_GOT_M: begin
                state_next.parse_state = (rx_byte == CH_A) ? PS_GOT_A : PS_HUNT;
            end
            PS_GOT_A: begin
                if (type_hit != FT_NONE) begin
                    state_next.frame_type  = type_hit;
                    state_next.parse_state = PS_PAYLOAD;
                end else begin
                    state_next.parse_state = PS_HUNT;
                end
            end
            PS_PAYLOAD: begin
                state_next.parse_state = PS_HUNT;
                res_next.value         = rx_byte;
                unique case (state_cur.frame_type)
                    FT_PANEL: begin
                        res_next.update_kind   = KIND_HUMIDITY;
                        state_next.parse_state = PS_PANEL2;
                    end
                    FT_INFO: begin
                        res_next.update_kind   = info_kind(rx_byte);
                        state_next.decode_flag = 1'b0;
                    end
                    FT_RTEMP: begin
                        res_next.update_kind   = KIND_REAL_TMP;
                        state_next.decode_flag = 1'b1;
                    end
                    FT_CMD: begin
                        res_next.update_kind   = KIND_COMMAND;
                        state_next.decode_flag = 1'b1;
                    end
                    FT_WIND: begin
                        res_next.update_kind   = KIND_WIND;
                        state_next.decode_flag = 1'b1;
                    end
                    FT_TIMER: begin
                        res_next.update_kind   = KIND_TIMER_HRS;
                        state_next.decode_flag = 1'b1;
                    end
                    FT_STEMP: begin
                        res_next.update_kind   = KIND_SET_TMP;
                        state_next.decode_flag = 1'b1;
                    end
                    FT_HOURS: begin
                        res_next.update_kind   = KIND_HOURS;
                        state_next.decode_flag = 1'b1;
                    end
                    FT_MIN: begin
                        // minutes frame leaves the stored frame type at hours
                        res_next.update_kind   = KIND_MINUTES;
                        state_next.decode_flag = 1'b1;
                        state_next.frame_type  = FT_HOURS;
                    end
                    FT_SEC: begin
                        res_next.update_kind   = KIND_SECONDS;
                        res_next.value         = rx_byte + 8'd1;
                        state_next.decode_flag = 1'b1;
                    end
                    default: begin
                        res_next.value = 8'd0;
                    end
                endcase
            end
            PS_PANEL2: begin
                state_next.parse_state = PS_HUNT;
                if (state_cur.frame_type == FT_PANEL) begin
                    res_next.update_kind   = KIND_PANEL_TMP;
                    res_next.value         = rx_byte;
                    state_next.decode_flag = 1'b1;
                end
            end
            default: begin
                state_next.parse_state = PS_HUNT;
                state_next.decode_flag = 1'b0;
            end
        endcase
        res_next.decode_ready = state_next.decode_flag;
    end

endmodule

[src/link_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// Link frame receiver.
// Input channel s_valid / s_ready / s_rx_byte carries one received serial byte
// per request. Frames are 'M' 'A' <type> <payload>; panel-data frames ('D')
// carry two payload bytes, humidity then temperature.
// Every byte gives exactly one result request on m_valid / m_ready with
// m_update_kind, m_value and m_decode_ready (decode flag after that byte).
// Path: m_valid rises once the byte has gone through the input register,
// then the parser logic into the result register.
// Throughput: one byte per cycle while m_ready does not stall the result, set
// by the combinational parser update of the frame state register.
// Reset (aresetn low, synchronous): parser goes back to hunting for 'M',
// frame type and decode flag clear, both pipeline stages empty.
// Stall: when m_ready is low the result holds; one more byte can sit in the
// input register, after which s_ready drops until the result is taken.
`include "assert_macros.svh"

module link_frame_receiver_unit
    import lfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_update_kind,
    output logic [7:0] m_value,
    output logic       m_decode_ready
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    lfr_state_t  state_reg;
    lfr_state_t  state_next;
    lfr_result_t res_next;
    logic        m_valid_reg;
    lfr_result_t res_reg;
    logic        advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    lfr_parser u_parser (
        .rx_byte    (in_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res_next   (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.parse_state <= PS_HUNT;
            state_reg.frame_type  <= FT_NONE;
            state_reg.decode_flag <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_update_kind  = res_reg.update_kind;
    assign m_value        = res_reg.value;
    assign m_decode_ready = res_reg.decode_ready;

    `ASSERT_PROP(a_none_zero_value, aclk, aresetn,
        (m_valid && m_update_kind == KIND_NONE) |-> (m_value == 8'd0),
        "no-update result carries a nonzero value")
    `ASSERT_PROP(a_flag_tracks_state, aclk, aresetn,
        advance |=> (m_decode_ready == state_reg.decode_flag),
        "decode_ready differs from the stored decode flag")
    `ASSERT_PROP(a_humidity_then_panel2, aclk, aresetn,
        (advance && res_next.update_kind == KIND_HUMIDITY)
            |=> (state_reg.parse_state == PS_PANEL2),
        "humidity update not followed by second panel byte state")
    `ASSERT_PROP(a_panel2_type, aclk, aresetn,
        (state_reg.parse_state == PS_PANEL2) |-> (state_reg.frame_type == FT_PANEL),
        "second panel byte state without panel frame type")
    `ASSERT_NEVER(a_full_no_ready, aclk, aresetn,
        in_valid_reg && m_valid_reg && !m_ready && s_ready,
        "input accepted while both stages are full and stalled")

endmodule
